>>> design/u16550_pkg.sv
// shared types, codes and constants for the 16550-style uart register block
package u16550_pkg;

  localparam int unsigned RX_DEPTH_DEFAULT = 16;
  localparam logic [31:0] BASE_ADDR_RESET  = 32'h1000_0000;

  localparam logic [7:0] IIR_PENDING = 8'hc0;
  localparam logic [7:0] IIR_NONE    = 8'hc1;
  localparam logic [7:0] LSR_THRE    = 8'h20;
  localparam logic [7:0] LSR_TEMT    = 8'h40;
  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam int unsigned IER_RX_BIT   = 0;
  localparam int unsigned IER_TX_BIT   = 1;
  localparam logic [3:0] LEGAL_SIZE    = 4'd1;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_LOAD  = 2'd1,
    FAULT_STORE = 2'd2
  } fault_e;

  typedef enum logic [2:0] {
    REG_RBR_THR = 3'd0,
    REG_IER     = 3'd1,
    REG_IIR_FCR = 3'd2,
    REG_LCR     = 3'd3,
    REG_MCR     = 3'd4,
    REG_LSR     = 3'd5,
    REG_MSR     = 3'd6,
    REG_SCR     = 3'd7
  } reg_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] offset;
    logic [3:0] access_size;
    logic [7:0] write_data;
    logic [7:0] line_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  fault;
    logic [32:0] fault_address;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
    logic        rx_dropped;
  } out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic not_empty;
    logic full;
    logic last;
  } fifo_status_t;

endpackage

>>> design/u16550_rx_fifo.sv
// receive fifo: circular buffer with a registered head byte
module u16550_rx_fifo #(
  parameter int unsigned RX_DEPTH = u16550_pkg::RX_DEPTH_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  u16550_pkg::fifo_ctrl_t    ctrl_i,
  input  logic [7:0]                push_data_i,
  output logic [7:0]                head_data_o,
  output u16550_pkg::fifo_status_t  status_o
);

  localparam int unsigned PtrW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RX_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  logic [7:0]      mem_q [RX_DEPTH];
  logic [7:0]      head_byte_q;
  logic [PtrW-1:0] head_q, head_d, head_inc, tail;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] tail_sum, tail_wrap;

  always_comb begin
    tail_sum  = SumW'(head_q) + SumW'(count_q);
    tail_wrap = (tail_sum >= SumW'(RX_DEPTH)) ? tail_sum - SumW'(RX_DEPTH) : tail_sum;
    tail      = tail_wrap[PtrW-1:0];
    head_inc  = (head_q == PtrW'(RX_DEPTH - 1)) ? '0 : head_q + 1'b1;
    head_d    = ctrl_i.pop ? head_inc : head_q;
    count_d   = count_q;
    if (ctrl_i.push) begin
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // head byte follows the next head; bypass a push that lands on it
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail] <= push_data_i;
    end
    if (ctrl_i.push && (tail == head_d)) begin
      head_byte_q <= push_data_i;
    end else begin
      head_byte_q <= mem_q[head_d];
    end
  end

  assign head_data_o        = head_byte_q;
  assign status_o.not_empty = (count_q != '0);
  assign status_o.full      = (count_q == CntW'(RX_DEPTH));
  assign status_o.last      = (count_q == CntW'(1));

endmodule

>>> design/uart_16550_register_block.sv
// top level of the 16550-style uart register block
//
// usage notes
// - input channel (in_valid_i / in_ready_o / in_data_i) carries one word per
//   item: a byte-wide bus read, a bus write, or a byte received on the line
// - output channel (out_valid_o / out_ready_i / out_data_o) returns exactly
//   one word per item, in order
// - config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the device
//   base address used in fault addresses; it is always ready and should only
//   be written while no items are in flight
// - execution: an accepted item is executed from the item register and its
//   result is registered in the result register, which drives out_valid_o,
//   once the output side is free
// - throughput: one item per cycle while out_ready_i is high; all register and
//   fifo updates for an item finish in the cycle in which it executes, and the
//   fifo head byte is prefetched from its memory into a register
// - stall: the result register holds while out_ready_i is low; the item
//   register can still take one more word, after which in_ready_o drops
// - reset: all control registers clear, the fifo is empty, base address is
//   0x10000000; the fifo memory needs no clearing pass
module uart_16550_register_block #(
  parameter int unsigned RX_DEPTH = u16550_pkg::RX_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  u16550_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output u16550_pkg::out_t  out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);

  // item register
  logic                     item_valid_q;
  u16550_pkg::in_t          item_q;
  // result register
  logic                     out_valid_q;
  u16550_pkg::out_t         out_q, out_d;
  // architectural registers
  logic [31:0]              base_q;
  logic [7:0]               dll_q, dll_d;
  logic [7:0]               dlm_q, dlm_d;
  logic [7:0]               ier_q, ier_d;
  logic [7:0]               lcr_q, lcr_d;
  logic [7:0]               mcr_q, mcr_d;
  logic [7:0]               scr_q, scr_d;
  logic                     thre_pend_q, thre_pend_d;
  // fifo interface
  u16550_pkg::fifo_ctrl_t   fifo_ctrl;
  u16550_pkg::fifo_status_t fifo_status;
  logic [7:0]               fifo_head;

  logic exec_fire;
  logic dlab;
  logic size_ok;
  logic irq_now;
  logic rx_nonempty_next;

  // execute whenever the result register is free or being drained
  assign exec_fire   = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !item_valid_q || exec_fire;
  assign cfg_ready_o = 1'b1;

  assign dlab    = lcr_q[u16550_pkg::LCR_DLAB_BIT];
  assign size_ok = (item_q.access_size == u16550_pkg::LEGAL_SIZE);
  assign irq_now = (ier_q[u16550_pkg::IER_RX_BIT] && fifo_status.not_empty) ||
                   (ier_q[u16550_pkg::IER_TX_BIT] && thre_pend_q);

  always_comb begin
    dll_d       = dll_q;
    dlm_d       = dlm_q;
    ier_d       = ier_q;
    lcr_d       = lcr_q;
    mcr_d       = mcr_q;
    scr_d       = scr_q;
    thre_pend_d = thre_pend_q;
    fifo_ctrl   = '0;
    out_d       = '0;

    case (item_q.command)
      u16550_pkg::CMD_READ: begin
        if (!size_ok) begin
          out_d.fault         = u16550_pkg::FAULT_LOAD;
          out_d.fault_address = {1'b0, base_q} + 33'(item_q.offset);
        end else begin
          case (item_q.offset[2:0])
            u16550_pkg::REG_RBR_THR: begin
              if (dlab) begin
                out_d.read_data = dll_q;
              end else if (fifo_status.not_empty) begin
                out_d.read_data = fifo_head;
                fifo_ctrl.pop   = exec_fire;
              end
            end
            u16550_pkg::REG_IER:     out_d.read_data = dlab ? dlm_q : ier_q;
            u16550_pkg::REG_IIR_FCR: begin
              // reading iir acknowledges the transmit-empty interrupt
              out_d.read_data = irq_now ? u16550_pkg::IIR_PENDING : u16550_pkg::IIR_NONE;
              thre_pend_d     = 1'b0;
            end
            u16550_pkg::REG_LCR:     out_d.read_data = lcr_q;
            u16550_pkg::REG_MCR:     out_d.read_data = mcr_q;
            u16550_pkg::REG_LSR: begin
              out_d.read_data = u16550_pkg::LSR_THRE | u16550_pkg::LSR_TEMT |
                                {7'd0, fifo_status.not_empty};
            end
            u16550_pkg::REG_MSR:     out_d.read_data = '0;
            u16550_pkg::REG_SCR:     out_d.read_data = scr_q;
            default:                 out_d.read_data = '0;
          endcase
        end
      end
      u16550_pkg::CMD_WRITE: begin
        if (!size_ok) begin
          out_d.fault         = u16550_pkg::FAULT_STORE;
          out_d.fault_address = {1'b0, base_q} + 33'(item_q.offset);
        end else begin
          case (item_q.offset[2:0])
            u16550_pkg::REG_RBR_THR: begin
              if (dlab) begin
                dll_d = item_q.write_data;
              end else begin
                // thr write goes straight out on the line
                out_d.tx_valid = 1'b1;
                out_d.tx_byte  = item_q.write_data;
                thre_pend_d    = 1'b1;
              end
            end
            u16550_pkg::REG_IER: begin
              if (dlab) begin
                dlm_d = item_q.write_data;
              end else begin
                ier_d = item_q.write_data;
              end
            end
            u16550_pkg::REG_LCR: lcr_d = item_q.write_data;
            u16550_pkg::REG_MCR: mcr_d = item_q.write_data;
            u16550_pkg::REG_SCR: scr_d = item_q.write_data;
            default: ;
          endcase
        end
      end
      u16550_pkg::CMD_RX: begin
        if (fifo_status.full) begin
          out_d.rx_dropped = 1'b1;
        end else begin
          fifo_ctrl.push = exec_fire;
        end
      end
      default: ;
    endcase

    // interrupt level after this item's updates
    rx_nonempty_next = (item_q.command == u16550_pkg::CMD_RX && !fifo_status.full) ||
                       (fifo_status.not_empty && !(fifo_ctrl.pop && fifo_status.last));
    out_d.irq = (ier_d[u16550_pkg::IER_RX_BIT] && rx_nonempty_next) ||
                (ier_d[u16550_pkg::IER_TX_BIT] && thre_pend_d);
  end

  u16550_rx_fifo #(
    .RX_DEPTH (RX_DEPTH)
  ) u_rx_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fifo_ctrl),
    .push_data_i (item_q.line_byte),
    .head_data_o (fifo_head),
    .status_o    (fifo_status)
  );

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      base_q       <= u16550_pkg::BASE_ADDR_RESET;
      dll_q        <= '0;
      dlm_q        <= '0;
      ier_q        <= '0;
      lcr_q        <= '0;
      mcr_q        <= '0;
      scr_q        <= '0;
      thre_pend_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      if (exec_fire) begin
        dll_q       <= dll_d;
        dlm_q       <= dlm_d;
        ier_q       <= ier_d;
        lcr_q       <= lcr_d;
        mcr_q       <= mcr_d;
        scr_q       <= scr_d;
        thre_pend_q <= thre_pend_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // fifo never pushed when full nor popped when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_ctrl.push |-> !fifo_status.full)
    else $error("rx fifo push while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_ctrl.pop |-> fifo_status.not_empty)
    else $error("rx fifo pop while empty");

  // a transmitted byte never comes with a fault or read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.tx_valid) |->
      (out_q.fault == u16550_pkg::FAULT_NONE && out_q.read_data == 8'd0))
    else $error("tx word carries fault or read data");

  // lcr, ier and the transmit-empty flag only move when an item executes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_fire |=> ($stable(lcr_q) && $stable(ier_q) && $stable(thre_pend_q)))
    else $error("register state changed without an executed item");

endmodule

>>> test/uart_16550_register_checker.sv
// checker for the uart register block: predicts every result word and compares it
`timescale 1ns / 1ps

module uart_16550_register_checker #(
  parameter int unsigned RX_DEPTH = u16550_pkg::RX_DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  u16550_pkg::in_t  in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  u16550_pkg::out_t out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [31:0]      cfg_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  // predicted words waiting for their result; two registers deep in the block
  localparam int unsigned WANT_DEPTH = 16;

  // shadow copy of the register file and receive fifo
  logic [31:0] base_addr;
  logic [7:0]  div_lo;
  logic [7:0]  div_hi;
  logic [7:0]  ier;
  logic [7:0]  lcr;
  logic [7:0]  mcr;
  logic [7:0]  scr;
  logic        thre_pending;
  logic [7:0]  rx_mem [RX_DEPTH];
  int unsigned rx_head;
  int unsigned rx_count;

  u16550_pkg::out_t want_mem [WANT_DEPTH];
  logic [3:0]       want_wr;
  logic [3:0]       want_rd;
  int unsigned      want_cnt;
  int unsigned      mismatches;
  int unsigned      word_idx;

  function automatic logic irq_now();
    return (ier[u16550_pkg::IER_RX_BIT] && rx_count != 0) ||
           (ier[u16550_pkg::IER_TX_BIT] && thre_pending);
  endfunction

  // applies one item to the shadow state and returns its result word
  function automatic u16550_pkg::out_t next_uart_result(u16550_pkg::in_t w);
    u16550_pkg::out_t r;
    logic dlab;
    u16550_pkg::reg_e sel;
    r = '0;
    dlab = lcr[u16550_pkg::LCR_DLAB_BIT];
    sel = u16550_pkg::reg_e'(w.offset[2:0]);
    if (w.command == u16550_pkg::CMD_READ || w.command == u16550_pkg::CMD_WRITE) begin
      if (w.access_size != u16550_pkg::LEGAL_SIZE) begin
        r.fault = (w.command == u16550_pkg::CMD_READ) ? u16550_pkg::FAULT_LOAD
                                                      : u16550_pkg::FAULT_STORE;
        r.fault_address = {1'b0, base_addr} + {25'd0, w.offset};
      end else if (w.command == u16550_pkg::CMD_READ) begin
        case (sel)
          u16550_pkg::REG_RBR_THR: begin
            if (dlab) begin
              r.read_data = div_lo;
            end else if (rx_count != 0) begin
              r.read_data = rx_mem[rx_head];
              rx_head = (rx_head + 1) % RX_DEPTH;
              rx_count--;
            end
          end
          u16550_pkg::REG_IER: r.read_data = dlab ? div_hi : ier;
          u16550_pkg::REG_IIR_FCR: begin
            r.read_data = irq_now() ? u16550_pkg::IIR_PENDING : u16550_pkg::IIR_NONE;
            thre_pending = 1'b0;
          end
          u16550_pkg::REG_LCR: r.read_data = lcr;
          u16550_pkg::REG_MCR: r.read_data = mcr;
          u16550_pkg::REG_LSR: begin
            r.read_data = u16550_pkg::LSR_THRE | u16550_pkg::LSR_TEMT |
                          {7'd0, rx_count != 0};
          end
          u16550_pkg::REG_MSR: r.read_data = 8'h00;
          default: r.read_data = scr;
        endcase
      end else begin
        case (sel)
          u16550_pkg::REG_RBR_THR: begin
            if (dlab) begin
              div_lo = w.write_data;
            end else begin
              r.tx_valid = 1'b1;
              r.tx_byte = w.write_data;
              thre_pending = 1'b1;
            end
          end
          u16550_pkg::REG_IER: begin
            if (dlab) div_hi = w.write_data;
            else ier = w.write_data;
          end
          u16550_pkg::REG_LCR: lcr = w.write_data;
          u16550_pkg::REG_MCR: mcr = w.write_data;
          u16550_pkg::REG_SCR: scr = w.write_data;
          default: ;
        endcase
      end
    end else if (w.command == u16550_pkg::CMD_RX) begin
      if (rx_count >= RX_DEPTH) begin
        r.rx_dropped = 1'b1;
      end else begin
        rx_mem[(rx_head + rx_count) % RX_DEPTH] = w.line_byte;
        rx_count++;
      end
    end
    r.irq = irq_now();
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    u16550_pkg::out_t want;
    if (!rst_ni) begin
      base_addr = u16550_pkg::BASE_ADDR_RESET;
      div_lo = '0;
      div_hi = '0;
      ier = '0;
      lcr = '0;
      mcr = '0;
      scr = '0;
      thre_pending = 1'b0;
      rx_head = 0;
      rx_count = 0;
      want_wr = '0;
      want_rd = '0;
      want_cnt = 0;
      mismatches = 0;
      word_idx = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) base_addr = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (want_cnt == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result word %0d: %h", word_idx, out_data_i);
          end
          mismatches++;
        end else begin
          want = want_mem[want_rd];
          want_rd = want_rd + 4'd1;
          want_cnt--;
          if (out_data_i !== want) begin
            if (mismatches < 10) begin
              $display("word %0d: rd %h/%h flt %0d/%0d addr %h/%h",
                       word_idx, want.read_data, out_data_i.read_data, want.fault,
                       out_data_i.fault, want.fault_address, out_data_i.fault_address);
              $display("  tx %b %h/%b %h irq %b/%b drop %b/%b",
                       want.tx_valid, want.tx_byte, out_data_i.tx_valid, out_data_i.tx_byte,
                       want.irq, out_data_i.irq, want.rx_dropped, out_data_i.rx_dropped);
            end
            mismatches++;
          end
        end
        word_idx++;
      end
      if (in_valid_i && in_ready_i) begin
        want_mem[want_wr] = next_uart_result(in_data_i);
        want_wr = want_wr + 4'd1;
        want_cnt++;
      end
      fail_count_o <= mismatches;
      pending_o <= want_cnt;
    end
  end

endmodule

>>> test/tb_uart_16550_register_block.sv
// testbench top for the uart register block: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module tb_uart_16550_register_block;

  // command code the block has no use for
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 500;
  localparam logic [3:0] SIZE_OK = u16550_pkg::LEGAL_SIZE;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  u16550_pkg::in_t  in_data = '0;
  logic             out_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [31:0]      cfg_data = '0;
  logic             in_ready;
  logic             out_valid;
  logic             cfg_ready;
  u16550_pkg::out_t out_data;
  int unsigned      fail_count;
  int unsigned      pending;

  // when set, neither side idles between words
  bit calm = 1'b0;

  always #5 clk = ~clk;

  uart_16550_register_block DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  uart_16550_register_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // bus words carry the same byte as write data and line byte
  function automatic u16550_pkg::in_t make_word(logic [1:0] cmd, logic [7:0] off,
                                                logic [3:0] size, logic [7:0] data);
    u16550_pkg::in_t w;
    w.command = cmd;
    w.offset = off;
    w.access_size = size;
    w.write_data = data;
    w.line_byte = data;
    return w;
  endfunction

  // mostly legal byte accesses and line bytes, some faults and unused commands
  function automatic u16550_pkg::in_t random_word();
    u16550_pkg::in_t w;
    int unsigned pick;
    w.offset = 8'($urandom_range(0, 255));
    w.access_size = SIZE_OK;
    w.write_data = 8'($urandom_range(0, 255));
    w.line_byte = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // offset and size are don't-care for line bytes
      w.command = u16550_pkg::CMD_RX;
      w.access_size = 4'($urandom_range(0, 15));
    end else if (pick < 62) begin
      w.command = u16550_pkg::CMD_READ;
    end else if (pick < 92) begin
      w.command = u16550_pkg::CMD_WRITE;
      // keep dlab mostly clear so rbr and thr stay reachable
      if (w.offset[2:0] == u16550_pkg::REG_LCR && $urandom_range(0, 3) != 0) begin
        w.write_data[u16550_pkg::LCR_DLAB_BIT] = 1'b0;
      end
    end else if (pick < 98) begin
      w.command = ($urandom_range(0, 1) != 0) ? u16550_pkg::CMD_WRITE : u16550_pkg::CMD_READ;
      do w.access_size = 4'($urandom_range(0, 15)); while (w.access_size == SIZE_OK);
    end else begin
      w.command = CMD_UNUSED;
    end
    return w;
  endfunction

  // valid only drops when a gap follows, so it never toggles within one step
  task automatic send_word(input u16550_pkg::in_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // the extra edge lets the checker count a word accepted at the last edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // base address may only change with no word in flight
  task automatic write_base(input logic [31:0] addr);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned n;
    u16550_pkg::in_t w;
    sent = 0;
    while (sent < count) begin
      // idle-free stretches come and go
      if ($urandom_range(0, 99) == 0) calm = ~calm;
      if ($urandom_range(0, 39) == 0) begin
        // fill the fifo, often past full, then drain some of it through rbr
        n = $urandom_range(12, 20);
        repeat (n) begin
          w = random_word();
          w.command = u16550_pkg::CMD_RX;
          send_word(w);
        end
        sent += n;
        n = $urandom_range(0, 20);
        repeat (n) begin
          w = random_word();
          w.command = u16550_pkg::CMD_READ;
          w.access_size = SIZE_OK;
          w.offset[2:0] = u16550_pkg::REG_RBR_THR;
          send_word(w);
        end
        sent += n;
      end else begin
        send_word(random_word());
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // result side: random stall before each word, ready held until it arrives
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // after reset: iir with nothing pending, lsr idle, rbr on an empty fifo
    send_word(make_word(u16550_pkg::CMD_READ, 8'h02, SIZE_OK, 8'h00));
    send_word(make_word(u16550_pkg::CMD_READ, 8'h05, SIZE_OK, 8'hff));
    send_word(make_word(u16550_pkg::CMD_READ, 8'h00, SIZE_OK, 8'h00));
    // enable both interrupts, send a byte, then fault an iir read (no clear)
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'h01, SIZE_OK, 8'h03));
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'h00, SIZE_OK, 8'hff));
    send_word(make_word(u16550_pkg::CMD_READ, 8'h02, 4'd8, 8'h00));
    send_word(make_word(u16550_pkg::CMD_READ, 8'hfa, SIZE_OK, 8'h00));
    // line bytes ignore offset and size
    send_word(make_word(u16550_pkg::CMD_RX, 8'hff, 4'hf, 8'h00));
    send_word(make_word(u16550_pkg::CMD_RX, 8'h00, 4'h0, 8'hff));
    send_word(make_word(u16550_pkg::CMD_READ, 8'h05, SIZE_OK, 8'h00));
    // faulted rbr read must not pop
    send_word(make_word(u16550_pkg::CMD_READ, 8'h00, 4'd2, 8'h00));
    send_word(make_word(u16550_pkg::CMD_READ, 8'h00, SIZE_OK, 8'h00));
    // divisor latch through dlab
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'h03, SIZE_OK, 8'h80));
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'h00, SIZE_OK, 8'ha5));
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'h01, SIZE_OK, 8'h5a));
    send_word(make_word(u16550_pkg::CMD_READ, 8'h00, SIZE_OK, 8'h00));
    send_word(make_word(u16550_pkg::CMD_READ, 8'h01, SIZE_OK, 8'h00));
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'h03, SIZE_OK, 8'h00));
    // mcr, scratch at the top offset, writes to fcr and lsr are dropped
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'h04, SIZE_OK, 8'hff));
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'hff, SIZE_OK, 8'h3c));
    send_word(make_word(u16550_pkg::CMD_READ, 8'hfc, SIZE_OK, 8'h00));
    send_word(make_word(u16550_pkg::CMD_READ, 8'h07, SIZE_OK, 8'h00));
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'h02, SIZE_OK, 8'hff));
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'h0d, SIZE_OK, 8'hff));
    send_word(make_word(u16550_pkg::CMD_READ, 8'h0e, SIZE_OK, 8'h00));
    // store fault and an unused command
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'hff, 4'hf, 8'h55));
    send_word(make_word(CMD_UNUSED, 8'h00, SIZE_OK, 8'haa));

    // top base address: fault address carries into bit 32
    write_base(32'hffff_ffff);
    send_word(make_word(u16550_pkg::CMD_READ, 8'hff, 4'h0, 8'h00));
    send_word(make_word(u16550_pkg::CMD_WRITE, 8'h80, 4'hf, 8'h00));

    write_base(32'h0000_0000);
    run_random(PHASE_WORDS);
    write_base($urandom);
    run_random(PHASE_WORDS);
    write_base(32'hffff_ffff);
    run_random(PHASE_WORDS);
    write_base($urandom);
    run_random(PHASE_WORDS);

    // let the last words come back, then wait for stray results
    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
